// ----- hw/rtl/lowest_free_id_allocator_macros.svh -----
// assertion macros shared by the checker of the lowest free id allocator
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LFIA_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define LFIA_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- hw/rtl/lfia_pkg.sv -----
// shared constants of the lowest free id allocator
package lfia_pkg;

	// field widths
	localparam int ID_W      = 11;
	localparam int POS_W     = ID_W + 1;
	localparam int CFG_W     = 11;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;

	// parameter defaults
	localparam int ID_SPACE_DEF  = 1024;
	localparam int WORD_BITS_DEF = 32;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_MIN_PID = 1'b0;
	localparam logic REG_MAX_PID = 1'b1;
	localparam logic [CFG_W-1:0] MIN_PID_RST = 11'd10;
	localparam logic [CFG_W-1:0] MAX_PID_RST = 11'd1000;

	// request kinds
	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_ALLOCATED   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL        = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RELEASED    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_RELEASE = 2'd3;

endpackage

// ----- hw/rtl/lowest_free_id_allocator.sv -----
// lowest free id allocator: bitmap in a word memory, scanned one word per cycle
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tuser: mode, tdata: release_id
//  m_axis    out        tvalid/tready          tuser: status, tdata: id
//  apb       in         psel/penable/pready    min_pid at 0x0, max_pid at 0x4
//
// a scanned request walks 1 .. ceil(ID_SPACE/WORD_BITS) bitmap words in the single word-wide
// scan unit, which reads one memory word per cycle
// a rejected request skips the scan
// after reset a clearing pass writes zero to every word,
// during which s_axis_tready stays low (configuration writes are still taken)
// a held result on m_axis does not stop the next request from being taken
module lowest_free_id_allocator #(
	parameter int ID_SPACE  = lfia_pkg::ID_SPACE_DEF,
	parameter int WORD_BITS = lfia_pkg::WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [lfia_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [10:0] release_id
	input  logic [0:0]                        s_axis_tuser,  // [0] mode
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [lfia_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [10:0] id
	output logic [lfia_pkg::STATUS_W-1:0]     m_axis_tuser,  // [1:0] status
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lfia_pkg::APB_AW-1:0]       paddr,
	input  logic [lfia_pkg::APB_DW-1:0]       pwdata,
	output logic [lfia_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);

	localparam int NUM_WORDS = (ID_SPACE + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int JW        = $clog2(WORD_BITS);
	localparam int HI_LIMIT  = ID_SPACE + 1;
	localparam logic [AW-1:0] LAST_W = AW'(NUM_WORDS - 1);
	localparam logic [lfia_pkg::POS_W-1:0] WB_POS = lfia_pkg::POS_W'(WORD_BITS);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [lfia_pkg::CFG_W-1:0] min_pid_q;
	logic [lfia_pkg::CFG_W-1:0] max_pid_q;
	logic                       cfg_wr;

	// request context
	logic                         mode_q;
	logic [lfia_pkg::ID_W-1:0]    rid_q;
	logic [lfia_pkg::POS_W-1:0]   lo_m1_q;
	logic [lfia_pkg::POS_W-1:0]   hi_m1_q;
	logic [lfia_pkg::POS_W-1:0]   rid_m1_q;

	// scan position: word index and first bit position of the word in rdata_q
	logic [AW-1:0]                w_q;
	logic [lfia_pkg::POS_W-1:0]   base_q;
	logic [AW-1:0]                clr_q;

	// pending and presented result
	logic [lfia_pkg::STATUS_W-1:0] res_status_q;
	logic [lfia_pkg::ID_W-1:0]     res_id_q;
	logic                          m_valid_q;
	logic [lfia_pkg::STATUS_W-1:0] m_status_q;
	logic [lfia_pkg::ID_W-1:0]     m_id_q;

	// bitmap memory
	logic [WORD_BITS-1:0] bitmap_q [NUM_WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [WORD_BITS-1:0] mem_wd;
	logic [AW-1:0]        mem_ra;

	// effective range of the request being taken
	logic [lfia_pkg::ID_W-1:0] lo_c;
	logic [lfia_pkg::ID_W-1:0] hi_c;
	logic                      range_empty;
	logic                      rel_outside;
	logic                      take;

	// word-wide scan unit
	logic [WORD_BITS-1:0]        in_range;
	logic [WORD_BITS-1:0]        free_bits;
	logic                        free_found;
	logic [JW-1:0]               free_idx;
	logic [lfia_pkg::POS_W-1:0]  base_end;
	logic                        alloc_last;
	logic                        rel_hit;
	logic [lfia_pkg::POS_W-1:0]  rel_off;
	logic [JW-1:0]               rel_idx;
	logic                        scan_write;
	logic                        scan_end;
	logic [WORD_BITS-1:0]        word_new;
	logic [AW-1:0]               w_next;
	logic [lfia_pkg::ID_W-1:0]   alloc_id;

	// apb: always ready, register index is paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			lfia_pkg::REG_MIN_PID: prdata[lfia_pkg::CFG_W-1:0] = min_pid_q;
			lfia_pkg::REG_MAX_PID: prdata[lfia_pkg::CFG_W-1:0] = max_pid_q;
			default:               prdata = '0;
		endcase
	end

	// clip the configured bounds to the id space
	always_comb begin
		lo_c = (min_pid_q == '0) ? lfia_pkg::ID_W'(1) : min_pid_q;
		if (32'(max_pid_q) > HI_LIMIT) begin
			hi_c = lfia_pkg::ID_W'(HI_LIMIT);
		end else begin
			hi_c = max_pid_q;
		end
		range_empty = (lo_c >= hi_c);
		rel_outside = (s_axis_tdata[lfia_pkg::ID_W-1:0] < lo_c)
			|| (s_axis_tdata[lfia_pkg::ID_W-1:0] >= hi_c);
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign take          = s_axis_tvalid && s_axis_tready;

	// per-bit window of the usable range inside the current word
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			in_range[j] = ((base_q + lfia_pkg::POS_W'(j)) >= lo_m1_q)
				&& ((base_q + lfia_pkg::POS_W'(j)) < hi_m1_q);
		end
	end

	assign free_bits  = ~rdata_q & in_range;
	assign free_found = |free_bits;

	// priority encoder, lowest free bit wins
	always_comb begin
		free_idx = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (free_bits[j]) begin
				free_idx = JW'(j);
			end
		end
	end

	assign base_end   = base_q + WB_POS;
	assign alloc_last = (base_end >= hi_m1_q);
	assign rel_hit    = (rid_m1_q < base_end);
	assign rel_off    = rid_m1_q - base_q;
	assign rel_idx    = rel_off[JW-1:0];
	assign alloc_id   = lfia_pkg::ID_W'(base_q + lfia_pkg::POS_W'(free_idx) + 1'b1);
	assign w_next     = (w_q == LAST_W) ? '0 : w_q + 1'b1;

	always_comb begin
		if (mode_q == lfia_pkg::MODE_ALLOC) begin
			scan_write = free_found;
			scan_end   = free_found || alloc_last;
			word_new   = rdata_q | (WORD_BITS'(1) << free_idx);
		end else begin
			scan_write = rel_hit;
			scan_end   = rel_hit;
			word_new   = rdata_q & ~(WORD_BITS'(1) << rel_idx);
		end
	end

	// memory port control: clearing pass, then write-back of the hit word
	assign mem_we = (state_q == S_CLEAR) || ((state_q == S_SCAN) && scan_write);
	assign mem_wa = (state_q == S_CLEAR) ? clr_q : w_q;
	assign mem_wd = (state_q == S_CLEAR) ? '0 : word_new;
	assign mem_ra = (state_q == S_IDLE) ? '0 : w_next;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_q[mem_wa] <= mem_wd;
		end
		rdata_q <= bitmap_q[mem_ra];
	end

	// sequencer, configuration registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			min_pid_q    <= lfia_pkg::MIN_PID_RST;
			max_pid_q    <= lfia_pkg::MAX_PID_RST;
			clr_q        <= '0;
			m_valid_q    <= 1'b0;
			mode_q       <= lfia_pkg::MODE_ALLOC;
			rid_q        <= '0;
			lo_m1_q      <= '0;
			hi_m1_q      <= '0;
			rid_m1_q     <= '0;
			w_q          <= '0;
			base_q       <= '0;
			res_status_q <= lfia_pkg::STAT_FULL;
			res_id_q     <= '0;
			m_status_q   <= lfia_pkg::STAT_FULL;
			m_id_q       <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					lfia_pkg::REG_MIN_PID: min_pid_q <= pwdata[lfia_pkg::CFG_W-1:0];
					lfia_pkg::REG_MAX_PID: max_pid_q <= pwdata[lfia_pkg::CFG_W-1:0];
					default: ;
				endcase
			end

			// the done state reloads the output register itself
			if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_W) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						mode_q   <= s_axis_tuser[0];
						rid_q    <= s_axis_tdata[lfia_pkg::ID_W-1:0];
						rid_m1_q <= lfia_pkg::POS_W'(s_axis_tdata[lfia_pkg::ID_W-1:0]) - 1'b1;
						lo_m1_q  <= lfia_pkg::POS_W'(lo_c) - 1'b1;
						hi_m1_q  <= lfia_pkg::POS_W'(hi_c) - 1'b1;
						w_q      <= '0;
						base_q   <= '0;
						// rejected requests skip the scan
						if (s_axis_tuser[0] == lfia_pkg::MODE_ALLOC && range_empty) begin
							res_status_q <= lfia_pkg::STAT_FULL;
							res_id_q     <= '0;
							state_q      <= S_DONE;
						end else if (s_axis_tuser[0] == lfia_pkg::MODE_RELEASE && rel_outside) begin
							res_status_q <= lfia_pkg::STAT_BAD_RELEASE;
							res_id_q     <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_DONE;
						if (mode_q == lfia_pkg::MODE_RELEASE) begin
							res_status_q <= lfia_pkg::STAT_RELEASED;
							res_id_q     <= rid_q;
						end else if (free_found) begin
							res_status_q <= lfia_pkg::STAT_ALLOCATED;
							res_id_q     <= alloc_id;
						end else begin
							res_status_q <= lfia_pkg::STAT_FULL;
							res_id_q     <= '0;
						end
					end else begin
						w_q    <= w_next;
						base_q <= base_end;
					end
				end
				S_DONE: begin
					// hand over once the output register is free
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_id_q     <= res_id_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = lfia_pkg::M_TDATA_W'(m_id_q);

endmodule

// ----- hw/rtl/lfia_chk.sv -----
// port checker of the lowest free id allocator and its bind
`include "lowest_free_id_allocator_macros.svh"

module lfia_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [lfia_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [lfia_pkg::STATUS_W-1:0]  m_axis_tuser
);

	// a stalled result holds
	`LFIA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// one request at a time: busy right after a transfer in
	`LFIA_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

	// full and rejected releases carry no id
	`LFIA_ASSERT_IMP(a_none_id_zero, m_axis_tvalid && (m_axis_tuser == lfia_pkg::STAT_FULL || m_axis_tuser == lfia_pkg::STAT_BAD_RELEASE), m_axis_tdata == '0, "id not zero on full or bad release")

	// handed out or released ids are never zero
	`LFIA_ASSERT_IMP(a_ok_id_set, m_axis_tvalid && (m_axis_tuser == lfia_pkg::STAT_ALLOCATED || m_axis_tuser == lfia_pkg::STAT_RELEASED), m_axis_tdata != '0, "zero id on success")

endmodule

bind lowest_free_id_allocator lfia_chk u_lfia_chk (.*);

// ----- tb/sv/tb_lowest_free_id_allocator.sv -----
// self-checking testbench for the lowest free id allocator
module tb_lowest_free_id_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_SPACE    = lfia_pkg::ID_SPACE_DEF;
	localparam int ID_W        = lfia_pkg::ID_W;
	localparam int CFG_W       = lfia_pkg::CFG_W;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_CAP   = 50;       // mismatch lines printed before going quiet

	// one request as the block sees it
	typedef struct packed {
		logic            mode;
		logic [ID_W-1:0] rid;
	} request_t;

	// one result as the block returns it
	typedef struct packed {
		logic [lfia_pkg::STATUS_W-1:0] status;
		logic [ID_W-1:0]               id;
	} result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [lfia_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;    // [10:0] release_id
	logic [0:0]                     s_axis_tuser = '0;    // [0] mode
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [lfia_pkg::M_TDATA_W-1:0] m_axis_tdata;         // [10:0] id
	logic [lfia_pkg::STATUS_W-1:0]  m_axis_tuser;         // [1:0] status
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [lfia_pkg::APB_AW-1:0]    paddr = '0;
	logic [lfia_pkg::APB_DW-1:0]    pwdata = '0;
	logic [lfia_pkg::APB_DW-1:0]    prdata;
	logic                           pready;

	lowest_free_id_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the allocator: bit k set means id k+1 is taken
	bit [ID_SPACE-1:0] id_map = '0;
	logic [CFG_W-1:0]  range_min = lfia_pkg::MIN_PID_RST;
	logic [CFG_W-1:0]  range_max = lfia_pkg::MAX_PID_RST;

	request_t request_q[$];     // requests waiting for the driver
	result_t  due_results[$];   // results owed by the block, oldest first
	int       mismatches = 0;
	int       cycle_count = 0;
	int       in_hold = 0;      // idle cycles before the next request is offered
	int       out_stall = 0;    // cycles m_axis_tready stays low
	bit       calm_in = 1'b0;   // stretches with no idling on the request side
	bit       calm_out = 1'b0;  // and on the result side
	request_t next_req;
	result_t  oldest;

	// lowest free id in [lo, hi) on allocate, clear the bit on release
	function automatic result_t grant_or_free(logic mode, logic [ID_W-1:0] rid);
		int      lo;
		int      hi;
		int      k;
		result_t r;
		lo = (range_min < 1) ? 1 : int'(range_min);
		hi = (range_max > ID_SPACE + 1) ? ID_SPACE + 1 : int'(range_max);
		r.status = lfia_pkg::STAT_FULL;
		r.id = '0;
		if (mode == lfia_pkg::MODE_ALLOC) begin
			// empty range and a fully used range both fall through as full
			for (k = lo; k < hi && r.status == lfia_pkg::STAT_FULL; k++)
				if (!id_map[k-1]) begin
					id_map[k-1] = 1'b1;
					r.status = lfia_pkg::STAT_ALLOCATED;
					r.id = k[ID_W-1:0];
				end
		end else if (int'(rid) < lo || int'(rid) >= hi) begin
			// outside the live range nothing changes
			r.status = lfia_pkg::STAT_BAD_RELEASE;
		end else begin
			// releasing a free id is fine and still echoes the id
			id_map[rid-1] = 1'b0;
			r.status = lfia_pkg::STAT_RELEASED;
			r.id = rid;
		end
		return r;
	endfunction

	// mostly short gaps, a few long ones, none during a calm stretch
	function automatic int pick_gap(bit calm);
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic push_req(input logic mode, input int rid);
		request_t r;
		r.mode = mode;
		r.rid = rid[ID_W-1:0];
		request_q.push_back(r);
	endtask

	// setup then access cycle; the register takes the value at the access edge
	task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == lfia_pkg::REG_MIN_PID)
			range_min = val;
		else
			range_max = val;
	endtask

	task automatic set_range(input int lo, input int hi);
		// write order varies so each register is sometimes written first
		if ($urandom_range(0, 1)) begin
			cfg_write(lfia_pkg::REG_MIN_PID, lo[CFG_W-1:0]);
			cfg_write(lfia_pkg::REG_MAX_PID, hi[CFG_W-1:0]);
		end else begin
			cfg_write(lfia_pkg::REG_MAX_PID, hi[CFG_W-1:0]);
			cfg_write(lfia_pkg::REG_MIN_PID, lo[CFG_W-1:0]);
		end
	endtask

	// sampled on the falling edge so the driver's own updates have settled
	task automatic drain();
		do @(negedge clk);
		while (request_q.size() != 0 || s_axis_tvalid || due_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// calm stretches come and go
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			calm_in <= !calm_in;
		if ($urandom_range(0, 199) == 0)
			calm_out <= !calm_out;
	end

	// request driver: predicts at each accepted transfer, then offers the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			in_hold = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				due_results.push_back(grant_or_free(s_axis_tuser[0], s_axis_tdata[ID_W-1:0]));
			// the slot is free when nothing is offered or the offer just went through
			if (!s_axis_tvalid || s_axis_tready) begin
				if (in_hold > 0) begin
					in_hold--;
					s_axis_tvalid <= 1'b0;
				end else if (request_q.size() != 0) begin
					next_req = request_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_req.rid;
					s_axis_tuser <= next_req.mode;
					in_hold = pick_gap(calm_in);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each transfer against the oldest owed result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d id %0d",
						m_axis_tuser, m_axis_tdata[ID_W-1:0]));
				end else begin
					oldest = due_results.pop_front();
					if (m_axis_tuser !== oldest.status)
						report_mismatch($sformatf("status %0d, expected %0d (id %0d)",
							m_axis_tuser, oldest.status, oldest.id));
					if (m_axis_tdata[ID_W-1:0] !== oldest.id)
						report_mismatch($sformatf("id %0d, expected %0d (status %0d)",
							m_axis_tdata[ID_W-1:0], oldest.id, oldest.status));
				end
			end
			// back-pressure: a stall of random length after each ready cycle
			if (out_stall > 0) begin
				out_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				out_stall = pick_gap(calm_out);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		int ph;
		int lo;
		int hi;
		int k;
		int a;
		int b;
		int sel;

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset range 10..999: first grants, release of a used and a free id,
		// releases just outside both ends, zero and the top of the id space
		push_req(lfia_pkg::MODE_ALLOC, 0);
		push_req(lfia_pkg::MODE_ALLOC, 1024);
		push_req(lfia_pkg::MODE_ALLOC, 2047);
		push_req(lfia_pkg::MODE_RELEASE, 11);
		push_req(lfia_pkg::MODE_RELEASE, 11);
		push_req(lfia_pkg::MODE_RELEASE, 0);
		push_req(lfia_pkg::MODE_RELEASE, 9);
		push_req(lfia_pkg::MODE_RELEASE, 1000);
		push_req(lfia_pkg::MODE_RELEASE, 999);
		push_req(lfia_pkg::MODE_RELEASE, 1024);
		push_req(lfia_pkg::MODE_ALLOC, 1023);
		drain();

		// widest range, ids below the old range now reachable
		set_range(1, 1025);
		push_req(lfia_pkg::MODE_ALLOC, 0);
		push_req(lfia_pkg::MODE_RELEASE, 1024);
		push_req(lfia_pkg::MODE_RELEASE, 1);
		push_req(lfia_pkg::MODE_ALLOC, 0);
		drain();

		// single id at the top of the space
		set_range(1024, 1025);
		push_req(lfia_pkg::MODE_ALLOC, 0);
		push_req(lfia_pkg::MODE_ALLOC, 0);
		push_req(lfia_pkg::MODE_RELEASE, 1024);
		push_req(lfia_pkg::MODE_RELEASE, 1023);
		drain();

		// empty range
		set_range(1024, 1);
		push_req(lfia_pkg::MODE_ALLOC, 0);
		push_req(lfia_pkg::MODE_RELEASE, 1);
		drain();

		// narrow range that fills up, older grants left outside it
		set_range(5, 8);
		push_req(lfia_pkg::MODE_ALLOC, 0);
		push_req(lfia_pkg::MODE_ALLOC, 0);
		push_req(lfia_pkg::MODE_ALLOC, 0);
		push_req(lfia_pkg::MODE_ALLOC, 0);
		drain();

		// random phases, each with its own range
		for (ph = 0; ph < 12; ph++) begin
			sel = $urandom_range(0, 9);
			if (ph == 0) begin
				lo = 1;
				hi = 1025;
			end else if (sel == 0) begin
				lo = $urandom_range(1, 1024);
				hi = $urandom_range(1, lo);
			end else if (sel == 1) begin
				lo = $urandom_range(990, 1024);
				hi = 1025;
			end else begin
				lo = $urandom_range(1, 1000);
				hi = lo + $urandom_range(1, 24);
			end
			set_range(lo, hi);
			// release ids mostly around the live range so they hit used bits
			a = (lo > 1) ? lo - 1 : 0;
			b = (hi > 1024) ? 1024 : hi;
			if (b < a)
				b = a;
			for (k = 0; k < 45; k++) begin
				if ($urandom_range(0, 99) < 55)
					push_req(lfia_pkg::MODE_ALLOC, $urandom_range(0, 1024));
				else if ($urandom_range(0, 4) != 0)
					push_req(lfia_pkg::MODE_RELEASE, $urandom_range(a, b));
				else
					push_req(lfia_pkg::MODE_RELEASE, $urandom_range(0, 1024));
			end
			drain();
		end

		// let any stray result show up
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
